[hw/rtl/srmp_pkg.sv]
// Shared types, register codes and helpers for the stepper trapezoid ramp block.
package srmp_pkg;

    // Default move counter width
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HALF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_DEC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EN    = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_MAX_HALF   = 16'd1200;
    localparam logic [15:0] RST_MIN_HALF   = 16'd900;
    localparam logic [11:0] RST_RAMP_STEPS = 12'd100;
    localparam logic [9:0]  RST_PERIOD_DEC = 10'd3;
    localparam logic        RST_KEEP_EN    = 1'b0;

    // Linear half period max - dec * level; covers any signed 16-bit level
    localparam int LIN_W = 28;

    typedef struct packed {
        logic [15:0] max_half;
        logic [15:0] min_half;
        logic [11:0] ramp_steps;
        logic [9:0]  period_dec;
        logic        keep_en;
    } cfg_t;

    typedef struct packed {
        logic step_level;
        logic dir_level;
        logic enable_n;
        logic busy;
        logic done;
    } res_t;

    // Saturate the linear half period to 1..65535
    function automatic logic [15:0] clamp_period(input logic signed [LIN_W-1:0] lin);
        logic [15:0] p;
        if (lin > $signed(LIN_W'(32'd65535)))
            p = 16'hFFFF;
        else if (lin < $signed(LIN_W'(32'd1)))
            p = 16'd1;
        else
            p = lin[15:0];
        return p;
    endfunction

endpackage

[hw/rtl/stepper_trapezoid_ramp_core.sv]
// Top level of the stepper trapezoid ramp step/direction generator.
//
// Input channel (in_valid / in_stall): each transfer is a one-microsecond tick
// (func = 0) or a move command (func = 1) with direction and step_count.
// Output channel (out_valid / out_stall): one result per input transfer, in
// order, showing the step, direction and enable pin levels after the item,
// a busy flag and a one-item move_done pulse.
// A result is written into the result buffer at its input transfer.
// Throughput: one item per cycle while in_stall is low; the sequencer updates
// all state per item; a two-entry result buffer decouples the output channel.
// When the receiver stalls, results collect in the buffer; in_stall rises
// once both entries hold results and falls after the next output transfer.
// Reset: registers return to their defaults (1200, 900, 100, 3, 0), the move
// state goes idle with step high and the driver disabled, the buffer empties.
// Configuration writes through cfg_we/cfg_index/cfg_data apply to every
// transfer after the write edge, also in the middle of a move.
module stepper_trapezoid_ramp_core
    import srmp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic                  direction,
    input  logic [15:0]           step_count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  step_level,
    output logic                  dir_level,
    output logic                  enable_n,
    output logic                  busy_res,
    output logic                  move_done,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t seq_res;
    res_t q_res;
    logic q_full;
    logic in_xfer;

    assign in_stall = q_full;
    assign in_xfer  = in_valid & ~q_full;

    srmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srmp_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_xfer),
        .func       (func),
        .direction  (direction),
        .step_count (step_count),
        .res        (seq_res)
    );

    srmp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (seq_res),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (q_res)
    );

    assign step_level = q_res.step_level;
    assign dir_level  = q_res.dir_level;
    assign enable_n   = q_res.enable_n;
    assign busy_res   = q_res.busy;
    assign move_done  = q_res.done;

endmodule

[hw/rtl/srmp_cfg.sv]
// Configuration registers of the stepper ramp block.
module srmp_cfg
    import srmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; writes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_HALF:   cfg_next.max_half   = cfg_data;
                CFG_MIN_HALF:   cfg_next.min_half   = cfg_data;
                CFG_RAMP_STEPS: cfg_next.ramp_steps = cfg_data[11:0];
                CFG_PERIOD_DEC: cfg_next.period_dec = cfg_data[9:0];
                CFG_KEEP_EN:    cfg_next.keep_en    = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_half   <= RST_MAX_HALF;
            cfg_reg.min_half   <= RST_MIN_HALF;
            cfg_reg.ramp_steps <= RST_RAMP_STEPS;
            cfg_reg.period_dec <= RST_PERIOD_DEC;
            cfg_reg.keep_en    <= RST_KEEP_EN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/srmp_seq.sv]
// Step sequencer: move state, ramp tracking and half-period timing.
module srmp_seq
    import srmp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  logic        func,
    input  logic        direction,
    input  logic [15:0] step_count,
    output res_t        res
);

    localparam int CW     = COUNT_BITS;
    localparam int CMP_W  = ((CW > 12) ? CW : 12) + 1;
    localparam int PROD_W = 27;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    localparam logic [1:0] KIND_CRUISE = 2'd0;
    localparam logic [1:0] KIND_ACCEL  = 2'd1;
    localparam logic [1:0] KIND_DECEL  = 2'd2;

    // Ramp phase of step i in a move of n steps
    function automatic logic [1:0] step_kind(
        input logic [CW-1:0] i,
        input logic [CW-1:0] n,
        input logic [11:0]   r
    );
        logic [CMP_W-1:0] ie;
        logic [CMP_W-1:0] ne;
        logic [CMP_W-1:0] re;
        logic [1:0]       k;
        ie = CMP_W'(i);
        ne = CMP_W'(n);
        re = CMP_W'(r);
        if (ne > (re << 1))
        begin
            if (ie < re)
                k = KIND_ACCEL;
            else if (ie > ne - re)
                k = KIND_DECEL;
            else
                k = KIND_CRUISE;
        end
        else if (ie < (ne >> 1))
        begin
            k = KIND_ACCEL;
        end
        else
        begin
            k = KIND_DECEL;
        end
        return k;
    endfunction

    logic [1:0]               phase_reg,  phase_next;
    logic [CW-1:0]            idx_reg,    idx_next;
    logic [CW-1:0]            total_reg,  total_next;
    logic [15:0]              level_reg,  level_next;
    logic [15:0]              timer_reg,  timer_next;
    logic                     dir_reg,    dir_next;
    logic                     enable_reg, enable_next;
    logic                     step_reg,   step_next;
    logic                     done;

    logic [CW-1:0]            cnt;
    logic [CW-1:0]            idx_inc;
    logic [15:0]              timer_dec;
    logic signed [LIN_W-1:0]  max_ext;
    logic [15:0]              level_step;
    logic [1:0]               kind_cur;
    logic [CW-1:0]            sel_idx;
    logic [CW-1:0]            sel_n;
    logic [15:0]              sel_level;
    logic signed [PROD_W-1:0] dec_wide;
    logic signed [PROD_W-1:0] lvl_wide;
    logic signed [PROD_W-1:0] dec_prod;
    logic signed [LIN_W-1:0]  sel_lin;
    logic [1:0]               sel_kind;
    logic [15:0]              period;

    assign cnt       = CW'(step_count);
    assign idx_inc   = idx_reg + CW'(1);
    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;
    assign max_ext   = $signed({{(LIN_W-16){1'b0}}, cfg.max_half});

    // Ramp level change after the current step
    assign kind_cur = step_kind(idx_reg, total_reg, cfg.ramp_steps);

    always_comb
    begin
        case (kind_cur)
            KIND_ACCEL: level_step = level_reg + 16'd1;
            KIND_DECEL: level_step = level_reg - 16'd1;
            default:    level_step = level_reg;
        endcase
    end

    // Step whose half period is loaded next
    always_comb
    begin
        if (func)
        begin
            sel_idx   = '0;
            sel_n     = cnt;
            sel_level = 16'd0;
        end
        else if (phase_reg == PH_LOW)
        begin
            sel_idx   = idx_reg;
            sel_n     = total_reg;
            sel_level = level_reg;
        end
        else
        begin
            sel_idx   = idx_inc;
            sel_n     = total_reg;
            sel_level = level_step;
        end
    end

    // Ramp half period from the live registers: max - dec * signed level
    assign dec_wide = $signed({{(PROD_W-10){1'b0}}, cfg.period_dec});
    assign lvl_wide = $signed({{(PROD_W-16){sel_level[15]}}, sel_level});
    assign dec_prod = dec_wide * lvl_wide;
    assign sel_lin  = max_ext - $signed({{(LIN_W-PROD_W){dec_prod[PROD_W-1]}}, dec_prod});

    assign sel_kind = step_kind(sel_idx, sel_n, cfg.ramp_steps);
    assign period   = (sel_kind == KIND_CRUISE) ? cfg.min_half : clamp_period(sel_lin);

    // Next state per transfer
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        level_next  = level_reg;
        timer_next  = timer_reg;
        dir_next    = dir_reg;
        enable_next = enable_reg;
        step_next   = step_reg;
        done        = 1'b0;
        if (item_valid)
        begin
            if (func)
            begin
                // Move command, dropped while a move runs
                if (phase_reg == PH_IDLE)
                begin
                    dir_next    = direction;
                    enable_next = 1'b0;
                    total_next  = cnt;
                    idx_next    = '0;
                    level_next  = 16'd0;
                    if (cnt == '0)
                    begin
                        phase_next  = PH_IDLE;
                        timer_next  = 16'd0;
                        enable_next = ~cfg.keep_en;
                        done        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LOW;
                        step_next  = 1'b0;
                        timer_next = period;
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                // Tick
                timer_next = timer_dec;
                if (timer_dec == 16'd0)
                begin
                    if (phase_reg == PH_LOW)
                    begin
                        phase_next = PH_HIGH;
                        step_next  = 1'b1;
                        timer_next = period;
                    end
                    else
                    begin
                        level_next = level_step;
                        idx_next   = idx_inc;
                        if (idx_inc == total_reg)
                        begin
                            phase_next  = PH_IDLE;
                            timer_next  = 16'd0;
                            enable_next = ~cfg.keep_en;
                            done        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LOW;
                            step_next  = 1'b0;
                            timer_next = period;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            idx_reg    <= '0;
            total_reg  <= '0;
            level_reg  <= 16'd0;
            timer_reg  <= 16'd0;
            dir_reg    <= 1'b0;
            enable_reg <= 1'b1;
            step_reg   <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            total_reg  <= total_next;
            level_reg  <= level_next;
            timer_reg  <= timer_next;
            dir_reg    <= dir_next;
            enable_reg <= enable_next;
            step_reg   <= step_next;
        end
    end

    // Result shows the state after the item
    assign res.step_level = step_next;
    assign res.dir_level  = dir_next;
    assign res.enable_n   = enable_next;
    assign res.busy       = (phase_next != PH_IDLE);
    assign res.done       = done;

endmodule

[hw/rtl/srmp_outq.sv]
// Two-entry result buffer between the sequencer and the output channel.
module srmp_outq
    import srmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg,   fill_next;
    logic       pop;

    assign out_valid = (fill_reg != 2'd0);
    assign full      = (fill_reg == 2'd2);
    assign pop       = out_valid & ~out_stall;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
